FILE: rtl/core/pmc_pkg.sv
`timescale 1ns / 1ps

package pmc_pkg;

    localparam int MAX_VERTICES_DEF = 16;

    localparam int VTX_W   = 4;
    localparam int NCNT_W  = 5;
    localparam int COUNT_W = 21;

    localparam int IN_A_LSB = 0;
    localparam int IN_B_LSB = IN_A_LSB + VTX_W;
    localparam int IN_N_LSB = IN_B_LSB + VTX_W;
    localparam int IN_TDATA_W  = ((IN_N_LSB + NCNT_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((COUNT_W + 7) / 8) * 8;

    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_COUNT    = 1'b1;

endpackage

FILE: rtl/core/perfect_matching_counter.sv
`timescale 1ns / 1ps
// Perfect matching counter.
// Input stream (s): one transaction per item. tuser is the operation:
//   add edge  - tdata carries vertex_a and vertex_b; sets one adjacency bit
//               for two distinct vertices and produces no output.
//   count     - tdata carries vertex_count; the block runs a backtracking
//               search over the loaded graph, emits the number of perfect
//               matchings on the output stream, then clears the graph.
// Output stream (m): one transaction per count item, pairing_count in tdata.
// The search steps through the nodes of the search tree with one shared
// priority-search unit that finds either the lowest free vertex or the next
// free neighbour.
// o_s_tready is high only while the search is idle, so one count is in work at
// a time; a finished count waits in the output register while the next input
// transaction is taken. If the receiver stalls, the search holds its result
// until the output register is free.
// Synchronous reset clears the graph, the search control and the output valid.
module perfect_matching_counter #(
    parameter int MAX_VERTICES = pmc_pkg::MAX_VERTICES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [3:0] vertex_a, [7:4] vertex_b, [12:8] vertex_count, [15:13] zero
    input  logic [pmc_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // [0] operation
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [20:0] pairing_count, [23:21] zero
    output logic [pmc_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int HALF = MAX_VERTICES / 2;
    localparam int SW   = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int DW   = $clog2(HALF + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FREE = 3'd1;
    localparam logic [2:0] S_PART = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                   r_state, n_state;
    logic [MAX_VERTICES-1:0]      r_adj [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]      r_mask;
    logic [VW-1:0]                r_stk_f [HALF];
    logic [VW-1:0]                r_stk_p [HALF];
    logic [DW-1:0]                r_depth;
    logic [pmc_pkg::COUNT_W-1:0]  r_acc;
    logic [VW-1:0]                r_f;
    logic [CW-1:0]                r_start;
    logic [CW-1:0]                r_n;
    logic                         r_out_valid;
    logic [pmc_pkg::COUNT_W-1:0]  r_out_data;

    logic [pmc_pkg::VTX_W-1:0]    in_a, in_b, in_lo, in_hi;
    logic [pmc_pkg::NCNT_W-1:0]   in_n;
    logic [CW-1:0]                in_n_sat;
    logic                         in_fire, edge_ok;

    logic [MAX_VERTICES-1:0]      nmask, u_cand, u_vec;
    logic [CW-1:0]                u_start;
    logic                         u_hit;
    logic [VW-1:0]                u_idx;
    logic [DW-1:0]                depth_m1;
    logic [SW-1:0]                pop_idx, push_idx;
    logic                         out_free;

    assign in_a  = i_s_tdata[pmc_pkg::IN_A_LSB +: pmc_pkg::VTX_W];
    assign in_b  = i_s_tdata[pmc_pkg::IN_B_LSB +: pmc_pkg::VTX_W];
    assign in_n  = i_s_tdata[pmc_pkg::IN_N_LSB +: pmc_pkg::NCNT_W];
    assign in_lo = (in_a < in_b) ? in_a : in_b;
    assign in_hi = (in_a < in_b) ? in_b : in_a;
    assign edge_ok = (in_a != in_b) && (int'(in_a) < MAX_VERTICES)
                     && (int'(in_b) < MAX_VERTICES);
    assign in_n_sat = (int'(in_n) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(in_n);

    assign o_s_tready = (r_state == S_IDLE);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    assign depth_m1 = r_depth - DW'(1);
    assign pop_idx  = depth_m1[SW-1:0];
    assign push_idx = r_depth[SW-1:0];

    // shared search unit: lowest candidate at or above u_start
    always_comb begin
        u_start = (r_state == S_PART) ? r_start : '0;
        for (int v = 0; v < MAX_VERTICES; v++) begin
            nmask[v] = CW'(v) < r_n;
        end
        u_cand = ~r_mask & nmask;
        if (r_state == S_PART) begin
            u_cand = u_cand & r_adj[r_f];
        end
        for (int v = 0; v < MAX_VERTICES; v++) begin
            u_vec[v] = u_cand[v] && (CW'(v) >= u_start);
        end
        u_hit = |u_vec;
        u_idx = '0;
        for (int v = MAX_VERTICES - 1; v >= 0; v--) begin
            if (u_vec[v]) begin
                u_idx = VW'(v);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && i_s_tuser == pmc_pkg::OP_COUNT) begin
                    n_state = S_FREE;
                end
            end
            S_FREE:  n_state = u_hit ? S_PART : S_POP;
            S_PART:  n_state = u_hit ? S_FREE : S_POP;
            S_POP:   n_state = (r_depth == '0) ? S_DONE : S_PART;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mask      <= '0;
            r_depth     <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            for (int r = 0; r < MAX_VERTICES; r++) begin
                r_adj[r] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_s_tuser == pmc_pkg::OP_ADD_EDGE) begin
                            if (edge_ok) begin
                                r_adj[in_lo[VW-1:0]][in_hi[VW-1:0]] <= 1'b1;
                            end
                        end else begin
                            r_n     <= in_n_sat;
                            r_mask  <= '0;
                            r_depth <= '0;
                            r_acc   <= '0;
                        end
                    end
                end
                S_FREE: begin
                    if (u_hit) begin
                        r_f     <= u_idx;
                        r_start <= CW'(u_idx) + CW'(1);
                    end else begin
                        r_acc <= r_acc + pmc_pkg::COUNT_W'(1);
                    end
                end
                S_PART: begin
                    if (u_hit) begin
                        r_stk_f[push_idx] <= r_f;
                        r_stk_p[push_idx] <= u_idx;
                        r_depth           <= r_depth + DW'(1);
                        r_mask            <= r_mask | (MAX_VERTICES'(1) << r_f)
                                             | (MAX_VERTICES'(1) << u_idx);
                    end
                end
                S_POP: begin
                    if (r_depth != '0) begin
                        r_depth <= depth_m1;
                        r_f     <= r_stk_f[pop_idx];
                        r_start <= CW'(r_stk_p[pop_idx]) + CW'(1);
                        r_mask  <= r_mask & ~((MAX_VERTICES'(1) << r_stk_f[pop_idx])
                                              | (MAX_VERTICES'(1) << r_stk_p[pop_idx]));
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_data  <= r_acc;
                        r_mask      <= '0;
                        r_depth     <= '0;
                        for (int r = 0; r < MAX_VERTICES; r++) begin
                            r_adj[r] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = pmc_pkg::OUT_TDATA_W'(r_out_data);

endmodule

FILE: rtl/core/pmc_checker.sv
`timescale 1ns / 1ps

module pmc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [pmc_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input logic                             i_s_tuser,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [pmc_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output changed while stalled");

    // a count transaction starts the search, input closes
    a_count_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == pmc_pkg::OP_COUNT |=> !o_s_tready)
        else $error("input open after count transaction");

    // an edge transaction never produces a result next cycle
    a_add_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == pmc_pkg::OP_ADD_EDGE && !o_m_tvalid
        |=> !o_m_tvalid)
        else $error("result after edge transaction");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("reset did not clear control");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[pmc_pkg::OUT_TDATA_W-1:pmc_pkg::COUNT_W] == '0)
        else $error("nonzero pad bits");

endmodule

bind perfect_matching_counter pmc_checker u_pmc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pmc_pkg::*;

    class pairing_scoreboard;
        logic [15:0]        adj [16];
        logic [COUNT_W-1:0] want_q [$];
        int                 errors;
        int                 results_seen;

        function new();
            foreach (adj[i]) adj[i] = '0;
            errors = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void note_item(input logic op, input logic [3:0] a, input logic [3:0] b,
                                input logic [4:0] n);
            int   nv, f, p, depth, total;
            int   lvl_f [8];
            int   lvl_p [8];
            logic [15:0] used;
            bit   done, resumed;
            if (op == OP_ADD_EDGE) begin
                if (a < b) begin
                    adj[a][b] = 1'b1;
                end else if (b < a) begin
                    adj[b][a] = 1'b1;
                end
                return;
            end
            nv = (n > 5'(MAX_VERTICES_DEF)) ? MAX_VERTICES_DEF : int'(n);
            used = '0;
            depth = 0;
            total = 0;
            done = 0;
            while (!done) begin
                f = nv;
                for (int v = nv - 1; v >= 0; v--) begin
                    if (!used[v]) f = v;
                end
                p = nv;
                if (f < nv) begin
                    for (int v = nv - 1; v > f; v--) begin
                        if (!used[v] && adj[f][v]) p = v;
                    end
                end else begin
                    total++;
                end
                if (f < nv && p < nv) begin
                    lvl_f[depth] = f;
                    lvl_p[depth] = p;
                    used[f] = 1'b1;
                    used[p] = 1'b1;
                    depth++;
                end else begin
                    resumed = 0;
                    while (depth > 0 && !resumed) begin
                        depth--;
                        f = lvl_f[depth];
                        used[f] = 1'b0;
                        used[lvl_p[depth]] = 1'b0;
                        p = nv;
                        for (int v = nv - 1; v > lvl_p[depth]; v--) begin
                            if (!used[v] && adj[f][v]) p = v;
                        end
                        if (p < nv) begin
                            lvl_p[depth] = p;
                            used[f] = 1'b1;
                            used[p] = 1'b1;
                            depth++;
                            resumed = 1;
                        end
                    end
                    done = !resumed;
                end
            end
            want_q.push_back(COUNT_W'(total));
            foreach (adj[i]) adj[i] = '0;
        endfunction

        function void check_result(input logic [OUT_TDATA_W-1:0] data);
            logic [COUNT_W-1:0] got, want;
            got = data[COUNT_W-1:0];
            results_seen++;
            if (want_q.size() == 0) begin
                $error("pairing_count: expected none, actual %0d", got);
                errors++;
            end else begin
                want = want_q.pop_front();
                if (got !== want) begin
                    $error("pairing_count: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tuser = OP_ADD_EDGE;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tready = 1'b0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;

    pairing_scoreboard sb;
    int  items_sent = 0;
    int  counts_sent = 0;
    bit  send_burst = 0;

    perfect_matching_counter dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_item(input logic op, input logic [3:0] a, input logic [3:0] b,
                             input logic [4:0] n);
        int gap;
        logic [IN_TDATA_W-1:0] word;
        if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 13);
        word = '0;
        word[IN_A_LSB +: VTX_W] = a;
        word[IN_B_LSB +: VTX_W] = b;
        word[IN_N_LSB +: NCNT_W] = n;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= word;
        do @(posedge clk); while (!s_tready);
        sb.note_item(op, a, b, n);
        items_sent++;
        if (op == OP_COUNT) counts_sent++;
    endtask

    task automatic send_edge(input int a, input int b);
        send_item(OP_ADD_EDGE, 4'(a), 4'(b), 5'($urandom));
    endtask

    task automatic send_count(input int n);
        send_item(OP_COUNT, 4'($urandom), 4'($urandom), 5'(n));
    endtask

    // receive side
    initial begin
        int gap;
        bit burst, held;
        burst = 0;
        held = 0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            if ($urandom_range(0, 15) == 0) burst = !burst;
            gap = burst ? 0 : $urandom_range(0, 13);
            if (!held && sb.results_seen == 3) begin
                gap = 400;
                held = 1;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial begin
        int kind, nv, neff, extra, j, t;
        int order [16];
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_count(0);
        send_count(1);
        send_edge(1, 0);
        send_edge(0, 1);
        send_edge(2, 2);
        send_edge(3, 9);
        send_edge(2, 3);
        send_count(4);
        for (int i = 7; i >= 0; i--) send_edge(2 * i + 1, 2 * i);
        send_count(31);
        send_edge(0, 1);
        send_edge(1, 2);
        send_edge(0, 2);
        send_count(3);
        send_count(16);

        // wait for the directed results before the random section
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);

        while (items_sent < 140 || counts_sent < 30) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) nv = $urandom_range(0, 8);
            else if (kind == 6) nv = $urandom_range(9, 16);
            else if (kind == 7) nv = $urandom_range(6, 10);
            else if (kind == 8) nv = $urandom_range(0, 16);
            else nv = $urandom_range(17, 31);
            neff = (nv > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : nv;

            if (kind == 7) begin
                extra = $urandom_range(10, 20);
                repeat (extra) send_edge($urandom_range(0, neff - 1), $urandom_range(0, neff - 1));
            end else if (kind == 8) begin
                extra = $urandom_range(0, 5);
                repeat (extra) send_edge($urandom_range(0, 15), $urandom_range(0, 15));
            end else begin
                for (int i = 0; i < 16; i++) order[i] = i;
                for (int i = neff - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    t = order[i];
                    order[i] = order[j];
                    order[j] = t;
                end
                for (int i = 0; i + 1 < neff; i += 2) send_edge(order[i], order[i + 1]);
                extra = (neff < 2) ? 0 : $urandom_range(0, 3);
                repeat (extra) send_edge($urandom_range(0, neff - 1), $urandom_range(0, neff - 1));
            end
            send_count(nv);
        end

        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (200) @(posedge clk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/pmc_pkg.sv
rtl/core/perfect_matching_counter.sv
rtl/core/pmc_checker.sv
verif/tb_top.sv
